FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is held
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// tdpc_pkg
// Shared constants, types and handshake structs of the trial division
// prime counter.
// ----------------------------------------------------------------------------
package tdpc_pkg;

  // widths of the request and result fields
  localparam int FIELD_VALUE_W = 16;
  localparam int FIELD_TOTAL_W = 16;

  // internal widths
  localparam int VALUE_WIDTH = 16;
  localparam int COUNT_WIDTH = 16;

  // divisors never exceed the square root of the value
  localparam int DIV_W    = (VALUE_WIDTH + 1) / 2;
  localparam int TRIAL_W  = DIV_W + 1;
  localparam int SQ_W     = 2 * DIV_W + 2;
  localparam int BITCNT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic start;
  } rem_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_sts_t;

  typedef struct packed {
    logic start;
    logic ack;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic prime;
  } seq_sts_t;

endpackage

FILE: sv/tdpc_in_if.sv
// ----------------------------------------------------------------------------
// tdpc_in_if
// Request channel: one value with its end-of-list flag.
// ----------------------------------------------------------------------------
interface tdpc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [tdpc_pkg::FIELD_VALUE_W-1:0]   value;
  logic                                 last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

FILE: sv/tdpc_out_if.sv
// ----------------------------------------------------------------------------
// tdpc_out_if
// Result channel: prime flag, running prime count and list end marker.
// ----------------------------------------------------------------------------
interface tdpc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 is_prime;
  logic [tdpc_pkg::FIELD_TOTAL_W-1:0]   prime_total;
  logic                                 list_done;

  modport source (output valid, output is_prime, output prime_total, output list_done,
                  input ready);
  modport sink   (input valid, input is_prime, input prime_total, input list_done,
                  output ready);
endinterface

FILE: sv/tdpc_rem.sv
// ----------------------------------------------------------------------------
// tdpc_rem
// Bit-serial restoring remainder unit: shifts in one dividend bit per cycle
// and reports whether the remainder is zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdpc_rem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tdpc_pkg::rem_ctl_t                ctl,
  input  logic [tdpc_pkg::VALUE_WIDTH-1:0]  dividend,
  input  logic [tdpc_pkg::TRIAL_W-1:0]      divisor,
  output tdpc_pkg::rem_sts_t                sts
);
  import tdpc_pkg::*;

  logic [TRIAL_W-1:0]     rem_r,  rem_nxt;
  logic [VALUE_WIDTH-1:0] dvd_r,  dvd_nxt;
  logic [BITCNT_W-1:0]    cnt_r,  cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  logic [TRIAL_W:0]       trial;
  logic [TRIAL_W:0]       dsr_ext;
  logic                   ge;

  assign trial   = {rem_r, dvd_r[VALUE_WIDTH-1]};
  assign dsr_ext = {1'b0, divisor};
  assign ge      = (trial >= dsr_ext);

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      cnt_nxt  = BITCNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial < 2*divisor, so the difference fits
      rem_nxt  = ge ? TRIAL_W'(trial - dsr_ext) : trial[TRIAL_W-1:0];
      dvd_nxt  = {dvd_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt  = cnt_r - BITCNT_W'(1);
      busy_nxt = (cnt_r != BITCNT_W'(1));
      done_nxt = (cnt_r == BITCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.zero = (rem_r == '0);

  `ASSERT_CLK(a_done_after_busy, clk, rst_n, done_r |-> ($past(busy_r) && !busy_r), "remainder done without a finished pass")

endmodule

FILE: sv/tdpc_seq.sv
// ----------------------------------------------------------------------------
// tdpc_seq
// Trial divisor sequencer: steps the divisor from two upward while its
// square stays within the value and none has divided it, one remainder pass per divisor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdpc_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tdpc_pkg::seq_ctl_t                ctl,
  input  logic [tdpc_pkg::VALUE_WIDTH-1:0]  value,
  output tdpc_pkg::seq_sts_t                sts
);
  import tdpc_pkg::*;

  seq_state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] val_r,   val_nxt;
  logic [TRIAL_W-1:0]     div_r,   div_nxt;
  logic [SQ_W-1:0]        sq_r,    sq_nxt;
  logic                   prime_r, prime_nxt;

  rem_ctl_t rem_ctl;
  rem_sts_t rem_sts;
  logic     sq_fits;

  assign sq_fits = (sq_r <= SQ_W'(val_r));

  tdpc_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (val_r),
    .divisor  (div_r),
    .sts      (rem_sts)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (ctl.start) state_nxt = S_TEST;
      S_TEST: state_nxt = sq_fits ? S_DIV : S_DONE;
      S_DIV: begin
        if (rem_sts.done) state_nxt = rem_sts.zero ? S_DONE : S_TEST;
      end
      S_DONE: if (ctl.ack) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    val_nxt       = val_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    prime_nxt     = prime_r;
    rem_ctl.start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          val_nxt   = value;
          div_nxt   = TRIAL_W'(2);
          sq_nxt    = SQ_W'(4);
          // zero and one are not prime
          prime_nxt = (value[VALUE_WIDTH-1:1] != '0);
        end
      end
      S_TEST: rem_ctl.start = sq_fits;
      S_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            prime_nxt = 1'b0;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt  = sq_r + SQ_W'({div_r, 1'b1});
            div_nxt = div_r + TRIAL_W'(1);
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    val_r   <= val_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
  end

  assign sts.idle  = (state_r == S_IDLE);
  assign sts.done  = (state_r == S_DONE);
  assign sts.prime = prime_r;

  `ASSERT_CLK(a_start_when_free, clk, rst_n, rem_ctl.start |-> !rem_sts.busy, "remainder pass started while busy")
  `ASSERT_CLK(a_hold_result, clk, rst_n, (state_r == S_DONE && !ctl.ack) |=> (state_r == S_DONE && $stable(prime_r)), "finished result not held")

endmodule

FILE: sv/trial_division_prime_counter_top.sv
// ----------------------------------------------------------------------------
// trial_division_prime_counter_top
// Primality test by trial division with a running prime count per list.
// ----------------------------------------------------------------------------
// One request is in work at a time. Each trial divisor takes a square check,
// a bit-serial remainder pass and a step to act on its result. Divisors run
// from two while their square stays within the value and stop at the first
// one that divides it. The result sits in an output register, so a new
// request is taken while the previous result waits to be read.
`include "assert_macros.svh"

module trial_division_prime_counter_top (
  input  logic              clk,
  input  logic              rst_n,
  tdpc_in_if.sink           in_chan,
  tdpc_out_if.source        out_chan
);
  import tdpc_pkg::*;

  seq_ctl_t seq_ctl;
  seq_sts_t seq_sts;

  logic                   last_r,      last_nxt;
  logic [COUNT_WIDTH-1:0] count_r,     count_nxt;
  logic                   out_vld_r,   out_vld_nxt;
  logic                   out_prime_r, out_prime_nxt;
  logic [COUNT_WIDTH-1:0] out_total_r, out_total_nxt;
  logic                   out_last_r,  out_last_nxt;

  logic                   in_fire;
  logic                   out_fire;
  logic                   load_out;
  logic [COUNT_WIDTH-1:0] total;

  assign in_chan.ready = seq_sts.idle;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_vld_r && out_chan.ready;
  assign load_out      = seq_sts.done && (!out_vld_r || out_chan.ready);

  assign seq_ctl.start = in_fire;
  assign seq_ctl.ack   = load_out;

  tdpc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (seq_ctl),
    .value (VALUE_WIDTH'(in_chan.value)),
    .sts   (seq_sts)
  );

  // saturating count including this item
  assign total = (seq_sts.prime && count_r != CNT_MAX) ? count_r + COUNT_WIDTH'(1) : count_r;

  always_comb begin
    last_nxt      = last_r;
    count_nxt     = count_r;
    out_vld_nxt   = out_vld_r;
    out_prime_nxt = out_prime_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    if (in_fire) last_nxt = in_chan.last_item;
    if (out_fire) out_vld_nxt = 1'b0;
    if (load_out) begin
      out_vld_nxt   = 1'b1;
      out_prime_nxt = seq_sts.prime;
      out_total_nxt = total;
      out_last_nxt  = last_r;
      count_nxt     = last_r ? '0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      count_r   <= count_nxt;
    end
    last_r      <= last_nxt;
    out_prime_r <= out_prime_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.is_prime    = out_prime_r;
  assign out_chan.prime_total = FIELD_TOTAL_W'(out_total_r);
  assign out_chan.list_done   = out_last_r;

  `ASSERT_CLK(a_count_clears, clk, rst_n, (load_out && last_r) |=> (count_r == '0), "count not cleared after end of list")

endmodule
